FILE: design/pfc_pkg.sv
`timescale 1ns / 1ps
// Package for the pixel format converter: format codes, register indexes,
// float decode/encode helpers and the types shared by the pipeline stages.
package pfc_pkg;

  localparam logic [3:0] FMT_R8    = 4'd0;
  localparam logic [3:0] FMT_R16F  = 4'd4;
  localparam logic [3:0] FMT_R32F  = 4'd8;
  localparam logic [3:0] FMT_LIMIT = 4'd12;

  localparam logic [1:0] CFG_SRC = 2'd0;
  localparam logic [1:0] CFG_DST = 2'd1;
  localparam logic [1:0] CFG_INV = 2'd2;

  localparam logic [31:0] ONE_F      = 32'h3F80_0000;
  localparam logic [31:0] HALF_MAX_F = 32'h477F_E000;
  localparam logic [31:0] INF_F      = 32'h7F80_0000;
  localparam logic [7:0]  UNORM_MAX  = 8'd255;

  // unorm8 encode classes
  localparam logic [1:0] UCLS_ZERO = 2'd0;
  localparam logic [1:0] UCLS_SAT  = 2'd1;
  localparam logic [1:0] UCLS_MUL  = 2'd2;

  typedef struct packed {
    logic        special;
    logic [31:0] sval;
    logic        sgn;
    logic [7:0]  exp;
    logic [50:0] sum;
  } inv_mid_t;

  function automatic logic [2:0] chan_count(input logic [3:0] fmt);
    logic [2:0] n;
    n = (fmt < FMT_LIMIT) ? ({1'b0, fmt[1:0]} + 3'd1) : 3'd0;
    return n;
  endfunction

  // x/255 has the byte repeating every 8 bits, so the rounding tail is never a tie
  function automatic logic [31:0] unorm8_to_f(input logic [7:0] x);
    logic [2:0]  p;
    logic [39:0] t;
    logic [22:0] man;
    logic [7:0]  ex;
    logic [31:0] res;
    p = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (x[i]) p = 3'(i);
    end
    t = {5{x}} << (3'd7 - p);
    man = t[38:16] + 23'(t[15]);
    ex = 8'd119 + {5'd0, p};
    if (x == 8'd0) res = 32'd0;
    else if (x == UNORM_MAX) res = ONE_F;
    else res = {1'b0, ex, man};
    return res;
  endfunction

  function automatic logic [31:0] half_to_f(input logic [15:0] h);
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  p;
    logic [23:0] mm;
    logic [31:0] res;
    e = h[14:10];
    m = h[9:0];
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) p = 4'(i);
    end
    mm = {14'd0, m} << (5'd23 - {1'b0, p});
    if (e == 5'd0) begin
      if (m == 10'd0) res = {h[15], 31'd0};
      else res = {h[15], 8'd103 + {4'd0, p}, mm[22:0]};
    end else if (e == 5'd31) begin
      res = {h[15], 8'hFF, m, 13'd0};
    end else begin
      res = {h[15], {3'd0, e} + 8'd112, m, 13'd0};
    end
    return res;
  endfunction

  function automatic logic [15:0] f_to_half(input logic [31:0] f);
    logic [30:0] a;
    logic [15:0] sgn;
    logic [7:0]  e;
    logic [7:0]  ed;
    logic [22:0] mant;
    logic [15:0] q;
    logic [12:0] r;
    logic [23:0] m;
    logic [4:0]  s;
    logic [23:0] qs;
    logic [23:0] rs;
    logic [23:0] hf;
    logic [15:0] res;
    a = f[30:0];
    // clamp to the half range; infinity clamps too, NaN does not
    if (a <= INF_F[30:0] && a > HALF_MAX_F[30:0]) a = HALF_MAX_F[30:0];
    sgn = {f[31], 15'd0};
    e = a[30:23];
    mant = a[22:0];
    ed = e - 8'd112;
    m = {1'b1, mant};
    s = 5'(8'd126 - e);
    qs = m >> s;
    rs = m & ((24'd1 << s) - 24'd1);
    hf = 24'd1 << (s - 5'd1);
    q = {1'b0, ed[4:0], mant[22:13]};
    r = mant[12:0];
    if (a > INF_F[30:0]) begin
      res = sgn | 16'h7E00;
    end else if (e >= 8'd113) begin
      if (r > 13'h1000 || (r == 13'h1000 && q[0])) q = q + 16'd1;
      res = sgn | {1'b0, q[14:0]};
    end else if (e < 8'd102) begin
      res = sgn;
    end else begin
      if (rs > hf || (rs == hf && qs[0])) qs = qs + 24'd1;
      res = sgn | qs[15:0];
    end
    return res;
  endfunction

  function automatic logic [1:0] unorm_class(input logic [31:0] x);
    logic [1:0] c;
    if (x[31] || x[30:0] == 31'd0 || x[30:0] > INF_F[30:0]) c = UCLS_ZERO;
    else if (x[30:0] > ONE_F[30:0]) c = UCLS_SAT;
    else c = UCLS_MUL;
    return c;
  endfunction

  // round the product x*255 to float precision, then truncate to an integer
  function automatic logic [7:0] unorm_finish(input logic [31:0] p, input logic [7:0] e);
    logic [24:0] qv;
    logic        up;
    logic [7:0]  sh;
    logic [24:0] val;
    if (p[31]) begin
      qv = {1'b0, p[31:8]};
      up = (p[7:0] > 8'h80) || (p[7:0] == 8'h80 && p[8]);
      sh = 8'd142 - e;
    end else begin
      qv = {1'b0, p[30:7]};
      up = (p[6:0] > 7'h40) || (p[6:0] == 7'h40 && p[7]);
      sh = 8'd143 - e;
    end
    qv = qv + 25'(up);
    val = (sh >= 8'd25) ? 25'd0 : (qv >> sh[4:0]);
    return val[7:0];
  endfunction

  // first half of 1 - x: specials, operand swap, alignment with sticky, add
  function automatic inv_mid_t inv_align(input logic [31:0] x);
    logic        xs;
    logic [7:0]  xe;
    logic [22:0] xm;
    logic [7:0]  be;
    logic [23:0] bm;
    logic [7:0]  el;
    logic [7:0]  es;
    logic [7:0]  d;
    logic [23:0] ml;
    logic [23:0] ms;
    logic [50:0] lw;
    logic [50:0] sw;
    logic [50:0] sh;
    logic [50:0] lostm;
    inv_mid_t    r;
    xs = x[31];
    xe = x[30:23];
    xm = x[22:0];
    be = (xe == 8'd0) ? 8'd1 : xe;
    bm = {xe != 8'd0, xm};
    r = '0;
    if ({be, bm} > {8'd127, 24'h80_0000}) begin
      el = be; ml = bm; es = 8'd127; ms = 24'h80_0000; r.sgn = ~xs;
    end else begin
      el = 8'd127; ml = 24'h80_0000; es = be; ms = bm; r.sgn = 1'b0;
    end
    d = el - es;
    lw = {1'b0, ml, 26'd0};
    sw = {1'b0, ms, 26'd0};
    lostm = '0;
    if (d > 8'd50) begin
      sh = {50'd0, |ms};
    end else begin
      sh = sw >> d;
      lostm = sw & ((51'd1 << d) - 51'd1);
      sh[0] = sh[0] | (|lostm);
    end
    r.exp = el;
    r.sum = xs ? (lw + sh) : (lw - sh);
    if (xe == 8'hFF && xm != 23'd0) begin
      r.special = 1'b1;
      r.sval = x | 32'h0040_0000;
    end else if (xe == 8'hFF) begin
      r.special = 1'b1;
      r.sval = {~xs, 8'hFF, 23'd0};
    end else if (xe == 8'd0 && xm == 23'd0) begin
      r.special = 1'b1;
      r.sval = ONE_F;
    end
    return r;
  endfunction

  // second half of 1 - x: leading-one search, normalize, round to nearest even
  function automatic logic [31:0] inv_round(input inv_mid_t m);
    logic [5:0]  k;
    logic [50:0] n;
    logic [22:0] man;
    logic [23:0] manr;
    logic        g;
    logic        st;
    logic [9:0]  er;
    logic [31:0] res;
    k = 6'd0;
    for (int i = 0; i < 51; i++) begin
      if (m.sum[i]) k = 6'(i);
    end
    n = m.sum << (6'd50 - k);
    man = n[49:27];
    g = n[26];
    st = |n[25:0];
    manr = {1'b0, man} + 24'(g && (st || man[0]));
    er = {2'd0, m.exp} + {4'd0, k} - 10'd49 + {9'd0, manr[23]};
    if (m.special) res = m.sval;
    else if (m.sum == 51'd0) res = 32'd0;
    else if (er >= 10'd255) res = {m.sgn, 8'hFF, 23'd0};
    else res = {m.sgn, er[7:0], manr[22:0]};
    return res;
  endfunction

endpackage

FILE: design/pixel_format_converter_top.sv
`timescale 1ns / 1ps
// Pixel format converter: decode, optional RGB invert, encode in five stages.
// Depends on pfc_pkg for format codes and the float helpers.
// Throughput: one pixel per cycle, set by
// the five-stage pipeline (decode, invert align/add, invert round, encode, pack).
// busy stays low; done cannot be held off. Synchronous reset clears the stage
// valid bits and sets source and destination format to RGBA8, invert off.
module pixel_format_converter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_red,
  input  logic [31:0] in_green,
  input  logic [31:0] in_blue,
  input  logic [31:0] in_alpha,
  output logic        done,
  output logic [31:0] out_red,
  output logic [31:0] out_green,
  output logic [31:0] out_blue,
  output logic [31:0] out_alpha,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);
  import pfc_pkg::*;

  logic [3:0] source_format;
  logic [3:0] dest_format;
  logic       invert_rgb;

  logic [31:0] in_w [4];
  logic [31:0] dec [4];
  logic [31:0] inv_c [4];
  logic [31:0] enc [4];
  logic [2:0]  ns;
  logic [2:0]  nd;
  logic        pass;

  logic        v1, v2, v3, v4;
  logic [31:0] raw1 [4];
  logic [31:0] raw2 [4];
  logic [31:0] raw3 [4];
  logic [31:0] raw4 [4];
  logic [31:0] c1 [4];
  logic [31:0] c2 [4];
  inv_mid_t    mid2 [3];
  logic [31:0] c3 [4];
  logic [31:0] f4 [4];
  logic [15:0] half4 [4];
  logic [31:0] prod4 [4];
  logic [7:0]  uexp4 [4];
  logic [1:0]  ucls4 [4];

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  assign in_w[0] = in_red;
  assign in_w[1] = in_green;
  assign in_w[2] = in_blue;
  assign in_w[3] = in_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= 4'd3;
      dest_format <= 4'd3;
      invert_rgb <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SRC: source_format <= cfg_data;
        CFG_DST: dest_format <= cfg_data;
        CFG_INV: invert_rgb <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign ns = chan_count(source_format);
  assign nd = chan_count(dest_format);
  assign pass = (source_format == dest_format) && !invert_rgb;

  // decode; missing channels take black with opaque alpha
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < ns) begin
        if (source_format < FMT_R16F) dec[i] = unorm8_to_f(in_w[i][7:0]);
        else if (source_format < FMT_R32F) dec[i] = half_to_f(in_w[i][15:0]);
        else dec[i] = in_w[i];
      end else begin
        dec[i] = (i == 3) ? ONE_F : 32'd0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      inv_c[i] = invert_rgb ? inv_round(mid2[i]) : c2[i];
    end
    inv_c[3] = c2[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      done <= v4;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      raw1[i] <= in_w[i];
      c1[i] <= dec[i];
      raw2[i] <= raw1[i];
      c2[i] <= c1[i];
      raw3[i] <= raw2[i];
      c3[i] <= inv_c[i];
      raw4[i] <= raw3[i];
      f4[i] <= c3[i];
      half4[i] <= f_to_half(c3[i]);
      prod4[i] <= {8'd0, c3[i][30:23] != 8'd0, c3[i][22:0]} * {24'd0, UNORM_MAX};
      uexp4[i] <= c3[i][30:23];
      ucls4[i] <= unorm_class(c3[i]);
    end
    for (int i = 0; i < 3; i++) begin
      mid2[i] <= inv_align(c1[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      enc[i] = 32'd0;
      if (3'(i) < nd) begin
        if (pass) begin
          if (dest_format < FMT_R16F) enc[i] = {24'd0, raw4[i][7:0]};
          else if (dest_format < FMT_R32F) enc[i] = {16'd0, raw4[i][15:0]};
          else enc[i] = raw4[i];
        end else if (dest_format < FMT_R16F) begin
          case (ucls4[i])
            UCLS_SAT: enc[i] = {24'd0, UNORM_MAX};
            UCLS_MUL: enc[i] = {24'd0, unorm_finish(prod4[i], uexp4[i])};
            default:  enc[i] = 32'd0;
          endcase
        end else if (dest_format < FMT_R32F) begin
          enc[i] = {16'd0, half4[i]};
        end else begin
          enc[i] = f4[i];
        end
      end
    end
  end

  // drive the result beat
  always_ff @(posedge clk) begin
    out_red <= enc[0];
    out_green <= enc[1];
    out_blue <= enc[2];
    out_alpha <= enc[3];
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##5 done)
    else $error("accepted pixel did not complete after five cycles");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(v4))
    else $error("done without a pixel in the last stage");

  a_unknown_dest: assert property (@(posedge clk) disable iff (rst)
    (done && dest_format >= FMT_LIMIT) |->
      (out_red == 32'd0 && out_green == 32'd0 && out_blue == 32'd0 && out_alpha == 32'd0))
    else $error("unknown destination format gave nonzero output");

  a_unorm_width: assert property (@(posedge clk) disable iff (rst)
    (done && dest_format < FMT_R16F) |->
      (out_red[31:8] == 24'd0 && out_green[31:8] == 24'd0 &&
       out_blue[31:8] == 24'd0 && out_alpha[31:8] == 24'd0))
    else $error("unorm8 output exceeds eight bits");
`endif

endmodule
